// File: rtl/core/imubcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imubcl_pkg
// Shared types and constants of the IMU bias calibration and low-pass core.
// ----------------------------------------------------------------------------
package imubcl_pkg;

    localparam int NUM_AXES    = 6;
    localparam int NUM_ACCEL   = 3;
    localparam int ACCEL_Z_IDX = 2;
    localparam int AXIS_W      = $clog2(NUM_AXES);

    localparam int RAW_W = 16;
    localparam int VAL_W = 25;
    localparam int CNT_W = 16;
    localparam int SUM_W = 32;
    localparam int WGT_W = 17;

    localparam int VAL_MAX = (1 << (VAL_W - 1)) - 1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CNT_W-1:0] RST_CAL_SAMPLES = 16'd12000;
    localparam logic [CNT_W-1:0] RST_ONE_G       = 16'd16384;
    localparam logic [WGT_W-1:0] RST_ACCEL_WGT   = 17'd9175;
    localparam logic [WGT_W-1:0] RST_GYRO_WGT    = 17'd6554;

    typedef logic signed [RAW_W-1:0] raw_t;
    typedef logic signed [VAL_W-1:0] val_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CAL_SAMPLES,
        REG_ONE_G,
        REG_ACCEL_WEIGHT,
        REG_GYRO_WEIGHT
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_CAL_OUT,
        ST_MUL,
        ST_UPD
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic acc;
        logic div_load;
        logic div_step;
        logic bias_store;
        logic mul;
        logic upd;
        logic cal_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic calib_phase;
        logic cal_done;
        logic div_last;
        logic axis_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/core/imubcl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imubcl_if
// Valid/ready channels for raw six-axis samples and filtered results.
// ----------------------------------------------------------------------------
interface imubcl_in_if;
    logic              valid;
    logic              ready;
    imubcl_pkg::raw_t  accel_x;
    imubcl_pkg::raw_t  accel_y;
    imubcl_pkg::raw_t  accel_z;
    imubcl_pkg::raw_t  gyro_x;
    imubcl_pkg::raw_t  gyro_y;
    imubcl_pkg::raw_t  gyro_z;

    modport source (
        output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        output ready
    );
endinterface

interface imubcl_out_if;
    logic              valid;
    logic              ready;
    imubcl_pkg::val_t  filt_accel_x;
    imubcl_pkg::val_t  filt_accel_y;
    imubcl_pkg::val_t  filt_accel_z;
    imubcl_pkg::val_t  filt_gyro_x;
    imubcl_pkg::val_t  filt_gyro_y;
    imubcl_pkg::val_t  filt_gyro_z;
    logic              calibrating;

    modport source (
        output valid, filt_accel_x, filt_accel_y, filt_accel_z,
               filt_gyro_x, filt_gyro_y, filt_gyro_z, calibrating,
        input  ready
    );
    modport sink (
        input  valid, filt_accel_x, filt_accel_y, filt_accel_z,
               filt_gyro_x, filt_gyro_y, filt_gyro_z, calibrating,
        output ready
    );
endinterface

// File: rtl/core/imu_bias_calibrate_lowpass_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bias_calibrate_lowpass_core
// Six-axis IMU bias calibration followed by a first-order low-pass filter.
// ----------------------------------------------------------------------------
// After reset the core sums calibration_samples raw samples per axis and
// answers each with an all-zero result flagged calibrating. A calibration
// sample goes through the input register and the accumulate step, its result
// then waiting for a free output register. The last one starts the bias
// division, a shared restoring divider that retires one quotient bit per
// cycle over 32 + FRACTION_BITS bits for each of the six axes, so that
// sample's result is ready only once all six biases are stored. After that
// each sample has its bias removed and runs through six parallel multiply
// lanes (input register, multiply, update steps), one sample in flight. The
// output register lets a finished result wait while the next sample is
// accepted. Results are counts with FRACTION_BITS fraction bits.
// ----------------------------------------------------------------------------
module imu_bias_calibrate_lowpass_core #(
    parameter int FRACTION_BITS = 8,
    parameter int WEIGHT_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    imubcl_in_if.sink                          imu_in,
    imubcl_out_if.source                       filt_out,
    input  logic                               cfg_we,
    input  logic [imubcl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [imubcl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    imubcl_pkg::ctrl_cmd_t  cmd;
    imubcl_pkg::dp_status_t sts;
    imubcl_pkg::raw_t       raw_in [imubcl_pkg::NUM_AXES];
    imubcl_pkg::val_t       out_vals [imubcl_pkg::NUM_AXES];
    logic                   in_ready;
    logic                   out_valid;
    logic                   out_cal;

    assign raw_in[0] = imu_in.accel_x;
    assign raw_in[1] = imu_in.accel_y;
    assign raw_in[2] = imu_in.accel_z;
    assign raw_in[3] = imu_in.gyro_x;
    assign raw_in[4] = imu_in.gyro_y;
    assign raw_in[5] = imu_in.gyro_z;
    assign imu_in.ready = in_ready;

    imubcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (imu_in.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    imubcl_datapath #(
        .FRACTION_BITS (FRACTION_BITS),
        .WEIGHT_BITS   (WEIGHT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .raw_in    (raw_in),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (filt_out.ready),
        .out_valid (out_valid),
        .out_vals  (out_vals),
        .out_cal   (out_cal)
    );

    assign filt_out.valid        = out_valid;
    assign filt_out.filt_accel_x = out_vals[0];
    assign filt_out.filt_accel_y = out_vals[1];
    assign filt_out.filt_accel_z = out_vals[2];
    assign filt_out.filt_gyro_x  = out_vals[3];
    assign filt_out.filt_gyro_y  = out_vals[4];
    assign filt_out.filt_gyro_z  = out_vals[5];
    assign filt_out.calibrating  = out_cal;

endmodule

// File: rtl/core/imubcl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imubcl_ctrl
// Sequencer: calibration accumulate, bias division per axis, filter update.
// ----------------------------------------------------------------------------
module imubcl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  imubcl_pkg::dp_status_t sts,
    output imubcl_pkg::ctrl_cmd_t  cmd
);

    imubcl_pkg::ctrl_state_t state_reg;
    imubcl_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imubcl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            imubcl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.calib_phase ? imubcl_pkg::ST_ACC : imubcl_pkg::ST_MUL;
                end
            end
            imubcl_pkg::ST_ACC:
            begin
                priority if (sts.cal_done)
                begin
                    state_next = imubcl_pkg::ST_DIV_LOAD;
                end
                else if (sts.out_free)
                begin
                    state_next = imubcl_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = imubcl_pkg::ST_CAL_OUT;
                end
            end
            imubcl_pkg::ST_DIV_LOAD:
            begin
                state_next = imubcl_pkg::ST_DIV_RUN;
            end
            imubcl_pkg::ST_DIV_RUN:
            begin
                if (sts.div_last)
                begin
                    state_next = imubcl_pkg::ST_DIV_STORE;
                end
            end
            imubcl_pkg::ST_DIV_STORE:
            begin
                state_next = sts.axis_last ? imubcl_pkg::ST_CAL_OUT : imubcl_pkg::ST_DIV_LOAD;
            end
            imubcl_pkg::ST_CAL_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = imubcl_pkg::ST_IDLE;
                end
            end
            imubcl_pkg::ST_MUL:
            begin
                state_next = imubcl_pkg::ST_UPD;
            end
            imubcl_pkg::ST_UPD:
            begin
                if (sts.out_free)
                begin
                    state_next = imubcl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = imubcl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            imubcl_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            imubcl_pkg::ST_ACC:
            begin
                cmd.acc     = 1'b1;
                cmd.cal_out = !sts.cal_done && sts.out_free;
            end
            imubcl_pkg::ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
            end
            imubcl_pkg::ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
            end
            imubcl_pkg::ST_DIV_STORE:
            begin
                cmd.bias_store = 1'b1;
            end
            imubcl_pkg::ST_CAL_OUT:
            begin
                cmd.cal_out = sts.out_free;
            end
            imubcl_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            imubcl_pkg::ST_UPD:
            begin
                cmd.upd = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/imubcl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imubcl_datapath
// Config registers, per-axis sums, bit-serial bias divider, six filter lanes
// and the output register.
// ----------------------------------------------------------------------------
module imubcl_datapath #(
    parameter int FRACTION_BITS = 8,
    parameter int WEIGHT_BITS   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [imubcl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [imubcl_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  imubcl_pkg::raw_t                       raw_in [imubcl_pkg::NUM_AXES],
    input  imubcl_pkg::ctrl_cmd_t                  cmd,
    output imubcl_pkg::dp_status_t                 sts,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output imubcl_pkg::val_t                       out_vals [imubcl_pkg::NUM_AXES],
    output logic                                   out_cal
);

    localparam int NA     = imubcl_pkg::NUM_AXES;
    localparam int VAL_W  = imubcl_pkg::VAL_W;
    localparam int CNT_W  = imubcl_pkg::CNT_W;
    localparam int SUM_W  = imubcl_pkg::SUM_W;
    localparam int WGT_W  = imubcl_pkg::WGT_W;
    localparam int AXIS_W = imubcl_pkg::AXIS_W;
    localparam int DIV_W  = SUM_W + FRACTION_BITS;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int BW     = DIV_W + 2;
    localparam int DW     = VAL_W + 1;
    localparam int PW     = WGT_W + 1 + DW;
    localparam int SW     = PW + 1;
    localparam int SAT_W  = (BW > SW) ? BW : SW;

    function automatic imubcl_pkg::val_t sat_val(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] vmax;
        logic signed [SAT_W-1:0] vmin;
        vmax = SAT_W'(imubcl_pkg::VAL_MAX);
        vmin = -vmax - SAT_W'(1);
        if (v > vmax)
        begin
            return vmax[VAL_W-1:0];
        end
        else if (v < vmin)
        begin
            return vmin[VAL_W-1:0];
        end
        return v[VAL_W-1:0];
    endfunction

    // configuration
    logic [CNT_W-1:0] cal_samples_reg;
    logic [CNT_W-1:0] one_g_reg;
    logic [WGT_W-1:0] accel_wgt_reg;
    logic [WGT_W-1:0] gyro_wgt_reg;

    // calibration state
    logic signed [SUM_W-1:0] sums_reg [NA];
    logic [CNT_W-1:0]        count_reg;
    logic                    calib_reg;
    imubcl_pkg::val_t        bias_reg [NA];
    imubcl_pkg::val_t        prev_reg [NA];

    // divider
    logic [AXIS_W-1:0] axis_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [DIV_W-1:0]  div_q_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic              sign_reg;

    // sample and filter lanes
    imubcl_pkg::raw_t        raw_reg [NA];
    imubcl_pkg::val_t        x_reg [NA];
    logic signed [PW-1:0]    prod_reg [NA];
    logic                    out_valid_reg;
    imubcl_pkg::val_t        out_vals_reg [NA];
    logic                    out_cal_reg;

    logic [CNT_W-1:0]        cnt_inc;
    logic [CNT_W-1:0]        divisor;
    logic [CNT_W:0]          rem_sh;
    logic [CNT_W:0]          rem_sub;
    logic                    q_bit;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [BW-1:0]    q_ext;
    logic signed [BW-1:0]    q_sgn;
    logic signed [BW-1:0]    og_term;
    imubcl_pkg::val_t        bias_calc;
    imubcl_pkg::val_t        x_next [NA];
    logic signed [DW-1:0]    d_lane [NA];
    logic [WGT_W-1:0]        w_lane [NA];
    imubcl_pkg::val_t        nv_lane [NA];

    always_comb
    begin
        cnt_inc = count_reg + CNT_W'(1);
        divisor = (count_reg == '0) ? CNT_W'(1) : count_reg;
        rem_sh  = {rem_reg, div_q_reg[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, divisor};
        q_bit   = (rem_sh >= {1'b0, divisor});
        sum_mag = sums_reg[axis_reg][SUM_W-1] ? SUM_W'(-sums_reg[axis_reg])
                                              : SUM_W'(sums_reg[axis_reg]);
        q_ext   = $signed({2'b00, div_q_reg});
        q_sgn   = sign_reg ? -q_ext : q_ext;
        og_term = (axis_reg == AXIS_W'(imubcl_pkg::ACCEL_Z_IDX))
                  ? $signed(BW'({one_g_reg, {FRACTION_BITS{1'b0}}})) : '0;
        bias_calc = sat_val(SAT_W'(q_sgn - og_term));
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            x_next[i]  = sat_val(SAT_W'($signed({raw_in[i], {FRACTION_BITS{1'b0}}}))
                                 - SAT_W'(bias_reg[i]));
            d_lane[i]  = DW'(x_reg[i]) - DW'(prev_reg[i]);
            w_lane[i]  = (i < imubcl_pkg::NUM_ACCEL) ? accel_wgt_reg : gyro_wgt_reg;
            nv_lane[i] = sat_val(SAT_W'(prev_reg[i]) + SAT_W'(prod_reg[i] >>> WEIGHT_BITS));
        end
    end

    always_comb
    begin
        sts.calib_phase = calib_reg;
        sts.cal_done    = (cnt_inc == '0) || (cnt_inc >= cal_samples_reg);
        sts.div_last    = (div_cnt_reg == DCNT_W'(1));
        sts.axis_last   = (axis_reg == AXIS_W'(NA - 1));
        sts.out_free    = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_samples_reg <= imubcl_pkg::RST_CAL_SAMPLES;
            one_g_reg       <= imubcl_pkg::RST_ONE_G;
            accel_wgt_reg   <= imubcl_pkg::RST_ACCEL_WGT;
            gyro_wgt_reg    <= imubcl_pkg::RST_GYRO_WGT;
        end
        else if (cfg_we)
        begin
            unique case (imubcl_pkg::cfg_reg_t'(cfg_index))
                imubcl_pkg::REG_CAL_SAMPLES:  cal_samples_reg <= cfg_data[CNT_W-1:0];
                imubcl_pkg::REG_ONE_G:        one_g_reg       <= cfg_data[CNT_W-1:0];
                imubcl_pkg::REG_ACCEL_WEIGHT: accel_wgt_reg   <= cfg_data[WGT_W-1:0];
                imubcl_pkg::REG_GYRO_WEIGHT:  gyro_wgt_reg    <= cfg_data[WGT_W-1:0];
                default:                      cal_samples_reg <= cal_samples_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            calib_reg   <= 1'b1;
            axis_reg    <= '0;
            div_cnt_reg <= '0;
            for (int i = 0; i < NA; i++)
            begin
                sums_reg[i] <= '0;
                bias_reg[i] <= '0;
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.acc)
            begin
                count_reg <= cnt_inc;
                for (int i = 0; i < NA; i++)
                begin
                    sums_reg[i] <= sums_reg[i] + SUM_W'(raw_reg[i]);
                end
            end
            if (cmd.div_load)
            begin
                div_cnt_reg <= DCNT_W'(DIV_W);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            end
            if (cmd.bias_store)
            begin
                bias_reg[axis_reg] <= bias_calc;
                if (sts.axis_last)
                begin
                    axis_reg  <= '0;
                    calib_reg <= 1'b0;
                end
                else
                begin
                    axis_reg <= axis_reg + AXIS_W'(1);
                end
            end
            if (cmd.upd)
            begin
                for (int i = 0; i < NA; i++)
                begin
                    prev_reg[i] <= nv_lane[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            for (int i = 0; i < NA; i++)
            begin
                raw_reg[i] <= raw_in[i];
                x_reg[i]   <= x_next[i];
            end
        end
        if (cmd.div_load)
        begin
            div_q_reg <= {sum_mag, {FRACTION_BITS{1'b0}}};
            rem_reg   <= '0;
            sign_reg  <= sums_reg[axis_reg][SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            div_q_reg <= {div_q_reg[DIV_W-2:0], q_bit};
            rem_reg   <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
        if (cmd.mul)
        begin
            for (int i = 0; i < NA; i++)
            begin
                prod_reg[i] <= $signed({1'b0, w_lane[i]}) * d_lane[i];
            end
        end
        if (cmd.upd)
        begin
            out_cal_reg <= 1'b0;
            for (int i = 0; i < NA; i++)
            begin
                out_vals_reg[i] <= nv_lane[i];
            end
        end
        else if (cmd.cal_out)
        begin
            out_cal_reg <= 1'b1;
            for (int i = 0; i < NA; i++)
            begin
                out_vals_reg[i] <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.upd || cmd.cal_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vals  = out_vals_reg;
    assign out_cal   = out_cal_reg;

endmodule

// File: tb/imu_bias_calibrate_lowpass_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bias_calibrate_lowpass_core_tb
// Self-checking testbench for the six-axis IMU bias calibration and low-pass core.
// ----------------------------------------------------------------------------
// The bench runs one calibration after reset, using extreme samples and
// lowering the sample count partway through. It then filters directed
// extremes and random samples under several accel and gyro weight settings,
// including zero, unity and overshoot. The handshake holds off on both
// channels at random, and one long receiver hold fills the core. A
// bit-accurate software model of the core predicts each result, and the
// results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module imu_bias_calibrate_lowpass_core_tb;

    localparam int FRAC_BITS  = 8;
    localparam int WGT_BITS   = 16;
    localparam int IDLE_LIMIT = 4000;
    localparam int END_WAIT   = 300;
    localparam int NA         = imubcl_pkg::NUM_AXES;

    typedef logic [NA-1:0][imubcl_pkg::RAW_W-1:0] sample_t;

    typedef struct packed {
        logic                                 cal;
        logic [NA-1:0][imubcl_pkg::VAL_W-1:0] axis;
    } result_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [imubcl_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [imubcl_pkg::CFG_DATA_W-1:0]  cfg_data;

    imubcl_in_if  imu_in ();
    imubcl_out_if filt_out ();

    imu_bias_calibrate_lowpass_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .imu_in    (imu_in),
        .filt_out  (filt_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies
    logic [imubcl_pkg::CNT_W-1:0] cal_samples_reg  = imubcl_pkg::RST_CAL_SAMPLES;
    logic [imubcl_pkg::CNT_W-1:0] one_g_reg        = imubcl_pkg::RST_ONE_G;
    logic [imubcl_pkg::WGT_W-1:0] accel_weight_reg = imubcl_pkg::RST_ACCEL_WGT;
    logic [imubcl_pkg::WGT_W-1:0] gyro_weight_reg  = imubcl_pkg::RST_GYRO_WGT;

    // filter and calibration state
    longint                       axis_sum   [NA];
    longint                       axis_bias  [NA];
    longint                       axis_prev  [NA];
    logic [imubcl_pkg::CNT_W-1:0] taken_count;
    bit                           in_calibration;

    result_t pending_results[$];
    int      mismatches  = 0;
    bit      tx_burst    = 0;
    bit      rx_burst    = 0;
    int      rx_hold_len = 0;
    int      idle_cycles = 0;

    string axis_names [NA] = '{"filt_accel_x", "filt_accel_y", "filt_accel_z",
                               "filt_gyro_x", "filt_gyro_y", "filt_gyro_z"};

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint clamp_val(input longint v);
        if (v > imubcl_pkg::VAL_MAX)
            return imubcl_pkg::VAL_MAX;
        if (v < -longint'(imubcl_pkg::VAL_MAX) - 1)
            return -longint'(imubcl_pkg::VAL_MAX) - 1;
        return v;
    endfunction

    function automatic result_t predict_filtered(input sample_t s);
        result_t r;
        longint  raw;
        longint  cnt;
        longint  b;
        longint  w;
        longint  x;
        longint  nv;
        r = '0;
        if (in_calibration)
        begin
            for (int i = 0; i < NA; i++)
                axis_sum[i] += longint'($signed(s[i]));
            taken_count = taken_count + 1'b1;
            if (taken_count >= cal_samples_reg || taken_count == '0)
            begin
                cnt = (taken_count == '0) ? 1 : longint'(taken_count);
                for (int i = 0; i < NA; i++)
                begin
                    b = (axis_sum[i] * (longint'(1) << FRAC_BITS)) / cnt;
                    if (i == imubcl_pkg::ACCEL_Z_IDX)
                        b -= longint'(one_g_reg) * (longint'(1) << FRAC_BITS);
                    axis_bias[i] = clamp_val(b);
                end
                in_calibration = 0;
            end
            r.cal = 1'b1;
        end
        else
        begin
            for (int i = 0; i < NA; i++)
            begin
                raw = longint'($signed(s[i]));
                w   = (i < imubcl_pkg::NUM_ACCEL) ? longint'(accel_weight_reg)
                                                  : longint'(gyro_weight_reg);
                x   = clamp_val(raw * (longint'(1) << FRAC_BITS) - axis_bias[i]);
                nv  = clamp_val(axis_prev[i] + ((w * (x - axis_prev[i])) >>> WGT_BITS));
                axis_prev[i] = nv;
                r.axis[i]    = nv[imubcl_pkg::VAL_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t make_sample(input int ax, input int ay, input int az,
                                            input int gx, input int gy, input int gz);
        sample_t s;
        s[0] = 16'(ax);
        s[1] = 16'(ay);
        s[2] = 16'(az);
        s[3] = 16'(gx);
        s[4] = 16'(gy);
        s[5] = 16'(gz);
        return s;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      r;
        for (int i = 0; i < NA; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                s[i] = 16'($urandom);
            else if (r < 85)
                case ($urandom_range(0, 3))
                    0:       s[i] = 16'h7fff;
                    1:       s[i] = 16'h8000;
                    2:       s[i] = 16'h0000;
                    default: s[i] = 16'hffff;
                endcase
            else
                s[i] = 16'($urandom_range(0, 1023) - 512);
        end
        return s;
    endfunction

    task automatic send_sample(input sample_t s);
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            imu_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        imu_in.valid   <= 1'b1;
        imu_in.accel_x <= s[0];
        imu_in.accel_y <= s[1];
        imu_in.accel_z <= s[2];
        imu_in.gyro_x  <= s[3];
        imu_in.gyro_y  <= s[4];
        imu_in.gyro_z  <= s[5];
        do
            @(posedge clk);
        while (!imu_in.ready);
        pending_results.push_back(predict_filtered(s));
    endtask

    task automatic drain_results();
        imu_in.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input imubcl_pkg::cfg_reg_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= imubcl_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            imubcl_pkg::REG_CAL_SAMPLES:  cal_samples_reg  = imubcl_pkg::CNT_W'(value);
            imubcl_pkg::REG_ONE_G:        one_g_reg        = imubcl_pkg::CNT_W'(value);
            imubcl_pkg::REG_ACCEL_WEIGHT: accel_weight_reg = imubcl_pkg::WGT_W'(value);
            imubcl_pkg::REG_GYRO_WEIGHT:  gyro_weight_reg  = imubcl_pkg::WGT_W'(value);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic test_calibration();
        tx_burst = 0;
        rx_burst = 0;
        cfg_write(imubcl_pkg::REG_CAL_SAMPLES, 65535);
        cfg_write(imubcl_pkg::REG_ONE_G, 0);
        send_sample(make_sample(32767, -32768, -32768, 32767, -32768, 1));
        send_sample(make_sample(-32768, 32767, -32768, -1, 32767, 0));
        send_sample(make_sample(32767, 0, -32768, -32768, -7, 3));
        send_sample(make_sample(-1, 1, -32768, 5, -32768, -2));
        drain_results();
        // lowered below the count taken so far, zero acts as one
        cfg_write(imubcl_pkg::REG_CAL_SAMPLES, 0);
        cfg_write(imubcl_pkg::REG_ONE_G, 65535);
        send_sample(make_sample(-3, 2, -32768, 0, 11, -32768));
        drain_results();
    endtask

    task automatic test_filter_extremes();
        cfg_write(imubcl_pkg::REG_ACCEL_WEIGHT, 65536);
        cfg_write(imubcl_pkg::REG_GYRO_WEIGHT, 65536);
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(make_sample(0, -1, 0, -1, 0, -1));
        drain_results();
        cfg_write(imubcl_pkg::REG_ACCEL_WEIGHT, 0);
        cfg_write(imubcl_pkg::REG_GYRO_WEIGHT, 0);
        send_sample(make_sample(32767, -32768, 32767, -32768, 32767, -32768));
        send_sample(make_sample(-32768, 32767, 0, 1, -1, 32767));
        drain_results();
        // weights above one overshoot into saturation
        cfg_write(imubcl_pkg::REG_ACCEL_WEIGHT, 131071);
        cfg_write(imubcl_pkg::REG_GYRO_WEIGHT, 131071);
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(make_sample(32767, -32768, 32767, -32768, 32767, -32768));
        send_sample(make_sample(-32768, 32767, -32768, 32767, -32768, 32767));
        drain_results();
        cfg_write(imubcl_pkg::REG_ACCEL_WEIGHT, 1);
        cfg_write(imubcl_pkg::REG_GYRO_WEIGHT, 65535);
        send_sample(make_sample(100, -100, 32767, -32768, 1, -1));
        drain_results();
    endtask

    task automatic test_backpressure();
        tx_burst = 1;
        rx_burst = 1;
        cfg_write(imubcl_pkg::REG_ACCEL_WEIGHT, imubcl_pkg::RST_ACCEL_WGT);
        cfg_write(imubcl_pkg::REG_GYRO_WEIGHT, imubcl_pkg::RST_GYRO_WGT);
        rx_hold_len = 300;
        repeat (30) send_sample(random_sample());
        drain_results();
    endtask

    task automatic test_random_filtering();
        sample_t s;
        s = random_sample();
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:
                begin
                    cfg_write(imubcl_pkg::REG_ACCEL_WEIGHT, imubcl_pkg::RST_ACCEL_WGT);
                    cfg_write(imubcl_pkg::REG_GYRO_WEIGHT, imubcl_pkg::RST_GYRO_WGT);
                end
                1:
                begin
                    cfg_write(imubcl_pkg::REG_ACCEL_WEIGHT, $urandom_range(0, 65536));
                    cfg_write(imubcl_pkg::REG_GYRO_WEIGHT, $urandom_range(0, 65536));
                end
                2:
                begin
                    cfg_write(imubcl_pkg::REG_ACCEL_WEIGHT, $urandom_range(0, 131071));
                    cfg_write(imubcl_pkg::REG_GYRO_WEIGHT, $urandom_range(0, 131071));
                end
                default:
                begin
                    cfg_write(imubcl_pkg::REG_ACCEL_WEIGHT,
                              $urandom_range(0, 1) ? 131071 : 0);
                    cfg_write(imubcl_pkg::REG_GYRO_WEIGHT, $urandom_range(0, 131071));
                end
            endcase
            // no effect once calibration is over
            if (p == 5)
            begin
                cfg_write(imubcl_pkg::REG_CAL_SAMPLES, $urandom_range(0, 65535));
                cfg_write(imubcl_pkg::REG_ONE_G, $urandom_range(0, 65535));
            end
            tx_burst = (p == 0) || ($urandom_range(0, 3) == 0);
            rx_burst = (p == 0) || ($urandom_range(0, 3) == 0);
            repeat (100)
            begin
                // steady runs let the filter settle
                if ($urandom_range(0, 9) >= 2)
                    s = random_sample();
                send_sample(s);
            end
            drain_results();
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        imu_in.valid   <= 1'b0;
        imu_in.accel_x <= '0;
        imu_in.accel_y <= '0;
        imu_in.accel_z <= '0;
        imu_in.gyro_x  <= '0;
        imu_in.gyro_y  <= '0;
        imu_in.gyro_z  <= '0;
        for (int i = 0; i < NA; i++)
        begin
            axis_sum[i]  = 0;
            axis_bias[i] = 0;
            axis_prev[i] = 0;
        end
        taken_count    = '0;
        in_calibration = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_calibration();
        test_filter_extremes();
        test_backpressure();
        test_random_filtering();
        drain_results();
        repeat (END_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("imu_bias_calibrate_lowpass_core verification clean");
        else
            $display("imu_bias_calibrate_lowpass_core verification failed");
        $finish;
    end

    // result receiver and checker
    initial
    begin : receiver
        result_t got;
        result_t want;
        int      stall_left;
        stall_left = 0;
        filt_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && filt_out.valid && filt_out.ready)
            begin
                got.cal     = filt_out.calibrating;
                got.axis[0] = filt_out.filt_accel_x;
                got.axis[1] = filt_out.filt_accel_y;
                got.axis[2] = filt_out.filt_accel_z;
                got.axis[3] = filt_out.filt_gyro_x;
                got.axis[4] = filt_out.filt_gyro_y;
                got.axis[5] = filt_out.filt_gyro_z;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected transaction, expected none actual calibrating %0b",
                             $time, got.cal);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.cal !== want.cal)
                    begin
                        mismatches++;
                        $display("%0t: calibrating expected %0b actual %0b",
                                 $time, want.cal, got.cal);
                    end
                    for (int i = 0; i < NA; i++)
                        if (got.axis[i] !== want.axis[i])
                        begin
                            mismatches++;
                            $display("%0t: %s expected %0d actual %0d", $time, axis_names[i],
                                     $signed(want.axis[i]), $signed(got.axis[i]));
                        end
                end
            end
            if (rx_hold_len > 0)
            begin
                stall_left  = rx_hold_len;
                rx_hold_len = 0;
            end
            else if (stall_left == 0 && !rx_burst && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                filt_out.ready <= 1'b0;
                stall_left--;
            end
            else
                filt_out.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((imu_in.valid && imu_in.ready) || (filt_out.valid && filt_out.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("imu_bias_calibrate_lowpass_core verification failed");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/core/imubcl_pkg.sv
rtl/core/imubcl_if.sv
rtl/core/imubcl_ctrl.sv
rtl/core/imubcl_datapath.sv
rtl/core/imu_bias_calibrate_lowpass_core.sv
tb/imu_bias_calibrate_lowpass_core_tb.sv
